[sv/sit_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and widths of the subset index translator.
package sit_pkg;

    // Field widths
    localparam int IDX_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Default table depths
    localparam int LOCAL_DEPTH_DEF  = 1024;
    localparam int REMOTE_DEPTH_DEF = 256;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR         = 3'd0,
        CMD_APPEND_LOCAL  = 3'd1,
        CMD_APPEND_REMOTE = 3'd2,
        CMD_FWD           = 3'd3,
        CMD_REV           = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_TOTAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_TOTAL = 3'd5;

    // Configuration register set
    typedef struct packed {
        logic [IDX_W-1:0] parent_first;
        logic [IDX_W-1:0] parent_limit;
        logic [IDX_W-1:0] parent_total;
        logic [IDX_W-1:0] subset_first;
        logic [IDX_W-1:0] subset_limit;
        logic [IDX_W-1:0] subset_total;
    } t_cfg;

endpackage

[sv/sit_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: command input, result output and configuration write.
interface sit_in_if import sit_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index_value;
    logic [IDX_W-1:0] remote_subset_value;

    modport source (output valid, command, index_value, remote_subset_value, input ready);
    modport sink   (input valid, command, index_value, remote_subset_value, output ready);
endinterface

interface sit_out_if import sit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  mapped_index;
    logic              found;
    logic [STAT_W-1:0] status;

    modport source (output valid, mapped_index, found, status, input ready);
    modport sink   (input valid, mapped_index, found, status, output ready);
endinterface

interface sit_cfg_if import sit_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [IDX_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/sit_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read.
module sit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, or registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sit_regs.sv]
`timescale 1ns / 1ps
// Configuration register file written through the configuration channel.
module sit_regs import sit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sit_cfg_if.sink   cfg_ch,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign cfg_ch.ready = 1'b1;

    // register write on each transfer; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                REG_PARENT_FIRST: r_cfg.parent_first <= cfg_ch.data;
                REG_PARENT_LIMIT: r_cfg.parent_limit <= cfg_ch.data;
                REG_PARENT_TOTAL: r_cfg.parent_total <= cfg_ch.data;
                REG_SUBSET_FIRST: r_cfg.subset_first <= cfg_ch.data;
                REG_SUBSET_LIMIT: r_cfg.subset_limit <= cfg_ch.data;
                REG_SUBSET_TOTAL: r_cfg.subset_total <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/sit_ctrl.sv]
`timescale 1ns / 1ps
// Command sequencer: table loads, binary search over the RAMs, result register.
module sit_ctrl import sit_pkg::*; #(
    parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
    parameter int REMOTE_DEPTH = REMOTE_DEPTH_DEF,
    localparam int LAW = $clog2(LOCAL_DEPTH),
    localparam int RAW = $clog2(REMOTE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    sit_in_if.sink             in_ch,
    sit_out_if.source          out_ch,
    // local table RAM
    output logic               o_lm_en,
    output logic               o_lm_we,
    output logic [LAW-1:0]     o_lm_addr,
    output logic [IDX_W-1:0]   o_lm_wdata,
    input  logic [IDX_W-1:0]   i_lm_rdata,
    // remote table RAM, word is {subset, parent}
    output logic               o_rm_en,
    output logic               o_rm_we,
    output logic [RAW-1:0]     o_rm_addr,
    output logic [2*IDX_W-1:0] o_rm_wdata,
    input  logic [2*IDX_W-1:0] i_rm_rdata
);

    localparam int LCW = $clog2(LOCAL_DEPTH + 1);
    localparam int RCW = $clog2(REMOTE_DEPTH + 1);
    localparam int SCW = (LCW > RCW) ? LCW : RCW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_SRCH,
        S_RLOC,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        M_FWD_LOCAL,
        M_FWD_REMOTE,
        M_REV_REMOTE
    } t_mode;

    t_state r_state, n_state;
    logic [LCW-1:0] r_lcnt, n_lcnt;
    logic [RCW-1:0] r_rcnt, n_rcnt;

    // captured item
    t_cmd r_cmd, n_cmd;
    logic [IDX_W-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_rsub, n_rsub;

    // search state
    t_mode r_mode, n_mode;
    logic [SCW-1:0] r_lo, n_lo;
    logic [SCW-1:0] r_hi, n_hi;
    logic [SCW-1:0] r_mid, n_mid;
    logic r_pend, n_pend;
    logic r_hset, n_hset;
    logic [2*IDX_W-1:0] r_hdata, n_hdata;

    // pending result
    logic [IDX_W-1:0] r_res_mapped, n_res_mapped;
    logic r_res_found, n_res_found;
    t_status r_res_status, n_res_status;

    // output register
    logic r_ovalid, n_ovalid;
    logic [IDX_W-1:0] r_omapped, n_omapped;
    logic r_ofound, n_ofound;
    t_status r_ostatus, n_ostatus;

    // search datapath terms
    logic [2*IDX_W-1:0] rd_word;
    logic [IDX_W-1:0] rd_key;
    logic [IDX_W-1:0] hd_key;
    logic [SCW-1:0] lo_c, hi_c, mid_c;
    logic hset_c;
    logic [2*IDX_W-1:0] hd_c;
    logic [IDX_W-1:0] rpos;

    assign in_ch.ready         = (r_state == S_IDLE);
    assign out_ch.valid        = r_ovalid;
    assign out_ch.mapped_index = r_omapped;
    assign out_ch.found        = r_ofound;
    assign out_ch.status       = r_ostatus;

    always_comb begin
        n_state      = r_state;
        n_lcnt       = r_lcnt;
        n_rcnt       = r_rcnt;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_rsub       = r_rsub;
        n_mode       = r_mode;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_pend       = r_pend;
        n_hset       = r_hset;
        n_hdata      = r_hdata;
        n_res_mapped = r_res_mapped;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid;
        n_omapped    = r_omapped;
        n_ofound     = r_ofound;
        n_ostatus    = r_ostatus;

        o_lm_en    = 1'b0;
        o_lm_we    = 1'b0;
        o_lm_addr  = r_lcnt[LAW-1:0];
        o_lm_wdata = r_key;
        o_rm_en    = 1'b0;
        o_rm_we    = 1'b0;
        o_rm_addr  = r_rcnt[RAW-1:0];
        o_rm_wdata = {r_rsub, r_key};

        // word just read, padded so both tables look alike
        rd_word = (r_mode == M_FWD_LOCAL) ? {{IDX_W{1'b0}}, i_lm_rdata} : i_rm_rdata;
        rd_key  = (r_mode == M_REV_REMOTE) ? rd_word[2*IDX_W-1:IDX_W] : rd_word[IDX_W-1:0];

        // fold the outstanding probe into the bounds
        lo_c   = r_lo;
        hi_c   = r_hi;
        hd_c   = r_hdata;
        hset_c = r_hset;
        if (r_pend) begin
            if (rd_key < r_key) begin
                lo_c = r_mid + SCW'(1);
            end else begin
                hi_c   = r_mid;
                hd_c   = rd_word;
                hset_c = 1'b1;
            end
        end
        mid_c  = lo_c + ((hi_c - lo_c) >> 1);
        hd_key = (r_mode == M_REV_REMOTE) ? hd_c[2*IDX_W-1:IDX_W] : hd_c[IDX_W-1:0];
        rpos   = r_key - i_cfg.subset_first;

        // output register drains on its own transfer
        if (r_ovalid && out_ch.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    n_cmd   = t_cmd'(in_ch.command);
                    n_key   = in_ch.index_value;
                    n_rsub  = in_ch.remote_subset_value;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_res_mapped = '0;
                n_res_found  = 1'b0;
                n_res_status = ST_OK;
                n_state      = S_PUSH;
                n_lo         = '0;
                n_pend       = 1'b0;
                n_hset       = 1'b0;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_lcnt = '0;
                        n_rcnt = '0;
                    end
                    CMD_APPEND_LOCAL: begin
                        if (r_lcnt >= LCW'(LOCAL_DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            o_lm_en      = 1'b1;
                            o_lm_we      = 1'b1;
                            n_res_mapped = IDX_W'(r_lcnt);
                            n_res_found  = 1'b1;
                            n_lcnt       = r_lcnt + LCW'(1);
                        end
                    end
                    CMD_APPEND_REMOTE: begin
                        if (r_rcnt >= RCW'(REMOTE_DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            o_rm_en      = 1'b1;
                            o_rm_we      = 1'b1;
                            n_res_mapped = IDX_W'(r_rcnt);
                            n_res_found  = 1'b1;
                            n_rcnt       = r_rcnt + RCW'(1);
                        end
                    end
                    CMD_FWD: begin
                        if (r_key >= i_cfg.parent_total) begin
                            n_res_status = ST_RANGE;
                        end else if (r_key >= i_cfg.parent_first &&
                                     r_key < i_cfg.parent_limit) begin
                            n_mode  = M_FWD_LOCAL;
                            n_hi    = SCW'(r_lcnt);
                            n_state = S_SRCH;
                        end else begin
                            n_mode  = M_FWD_REMOTE;
                            n_hi    = SCW'(r_rcnt);
                            n_state = S_SRCH;
                        end
                    end
                    CMD_REV: begin
                        if (r_key >= i_cfg.subset_total) begin
                            n_res_status = ST_RANGE;
                        end else if (r_key >= i_cfg.subset_first &&
                                     r_key < i_cfg.subset_limit) begin
                            // local range maps by offset into the local table
                            if (rpos < IDX_W'(r_lcnt)) begin
                                o_lm_en   = 1'b1;
                                o_lm_addr = rpos[LAW-1:0];
                                n_state   = S_RLOC;
                            end else begin
                                n_res_status = ST_MISS;
                            end
                        end else begin
                            n_mode  = M_REV_REMOTE;
                            n_hi    = SCW'(r_rcnt);
                            n_state = S_SRCH;
                        end
                    end
                    default: ;
                endcase
            end

            S_SRCH: begin
                n_lo    = lo_c;
                n_hi    = hi_c;
                n_hdata = hd_c;
                n_hset  = hset_c;
                if (lo_c < hi_c) begin
                    // next probe issues in the cycle the last one returns
                    n_mid  = mid_c;
                    n_pend = 1'b1;
                    if (r_mode == M_FWD_LOCAL) begin
                        o_lm_en   = 1'b1;
                        o_lm_addr = mid_c[LAW-1:0];
                    end else begin
                        o_rm_en   = 1'b1;
                        o_rm_addr = mid_c[RAW-1:0];
                    end
                end else begin
                    // lower bound found; hit only on an exact match at it
                    n_pend  = 1'b0;
                    n_state = S_PUSH;
                    if (hset_c && hd_key == r_key) begin
                        n_res_found  = 1'b1;
                        n_res_status = ST_OK;
                        case (r_mode)
                            M_FWD_LOCAL:  n_res_mapped = IDX_W'(lo_c) + i_cfg.subset_first;
                            M_FWD_REMOTE: n_res_mapped = hd_c[2*IDX_W-1:IDX_W];
                            default:      n_res_mapped = hd_c[IDX_W-1:0];
                        endcase
                    end else begin
                        n_res_found  = 1'b0;
                        n_res_mapped = '0;
                        n_res_status = (r_mode == M_REV_REMOTE) ? ST_MISS : ST_OK;
                    end
                end
            end

            S_RLOC: begin
                n_res_mapped = i_lm_rdata;
                n_res_found  = 1'b1;
                n_res_status = ST_OK;
                n_state      = S_PUSH;
            end

            S_PUSH: begin
                if (!r_ovalid || out_ch.ready) begin
                    n_ovalid  = 1'b1;
                    n_omapped = r_res_mapped;
                    n_ofound  = r_res_found;
                    n_ostatus = r_res_status;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lcnt   <= n_lcnt;
            r_rcnt   <= n_rcnt;
            r_ovalid <= n_ovalid;
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_rsub       <= n_rsub;
        r_mode       <= n_mode;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_pend       <= n_pend;
        r_hset       <= n_hset;
        r_hdata      <= n_hdata;
        r_res_mapped <= n_res_mapped;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_omapped    <= n_omapped;
        r_ofound     <= n_ofound;
        r_ostatus    <= n_ostatus;
    end

endmodule

[sv/subset_index_translator.sv]
`timescale 1ns / 1ps
// Top level of the subset index translator: registers, sequencer and table RAMs.
// One command at a time. Lookups: one RAM read per binary search probe; a local
// reverse hit reads the local table once, at the key's offset from the subset base.
// The result goes to the output register, which holds it until it is taken.
// Reset (synchronous, active low) zeroes registers and counts; RAMs keep contents.
module subset_index_translator import sit_pkg::*; #(
    parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
    parameter int REMOTE_DEPTH = REMOTE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sit_in_if.sink    in_ch,
    sit_out_if.source out_ch,
    sit_cfg_if.sink   cfg_ch
);

    localparam int LAW = $clog2(LOCAL_DEPTH);
    localparam int RAW = $clog2(REMOTE_DEPTH);

    t_cfg cfg;

    logic               lm_en, lm_we;
    logic [LAW-1:0]     lm_addr;
    logic [IDX_W-1:0]   lm_wdata, lm_rdata;
    logic               rm_en, rm_we;
    logic [RAW-1:0]     rm_addr;
    logic [2*IDX_W-1:0] rm_wdata, rm_rdata;

    // configuration registers
    sit_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg_ch  (cfg_ch),
        .o_cfg   (cfg)
    );

    // command sequencer
    sit_ctrl #(
        .LOCAL_DEPTH  (LOCAL_DEPTH),
        .REMOTE_DEPTH (REMOTE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_lm_en    (lm_en),
        .o_lm_we    (lm_we),
        .o_lm_addr  (lm_addr),
        .o_lm_wdata (lm_wdata),
        .i_lm_rdata (lm_rdata),
        .o_rm_en    (rm_en),
        .o_rm_we    (rm_we),
        .o_rm_addr  (rm_addr),
        .o_rm_wdata (rm_wdata),
        .i_rm_rdata (rm_rdata)
    );

    // local parent table
    sit_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LOCAL_DEPTH)
    ) u_local_ram (
        .i_clk   (i_clk),
        .i_en    (lm_en),
        .i_we    (lm_we),
        .i_addr  (lm_addr),
        .i_wdata (lm_wdata),
        .o_rdata (lm_rdata)
    );

    // remote pair table
    sit_ram #(
        .WIDTH (2*IDX_W),
        .DEPTH (REMOTE_DEPTH)
    ) u_remote_ram (
        .i_clk   (i_clk),
        .i_en    (rm_en),
        .i_we    (rm_we),
        .i_addr  (rm_addr),
        .i_wdata (rm_wdata),
        .o_rdata (rm_rdata)
    );

endmodule

[sv/sit_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the subset index translator, bound to the top level.
module sit_checker import sit_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [IDX_W-1:0]  i_mapped_index,
    input logic              i_found,
    input logic [STAT_W-1:0] i_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one command in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a command is in flight");

    // a hit always carries ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_status == ST_OK)
        else $error("hit with error status");

    // misses and errors report index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_mapped_index == '0)
        else $error("miss with nonzero index");

endmodule

bind subset_index_translator sit_checker u_sit_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (in_ch.valid),
    .i_in_ready     (in_ch.ready),
    .i_out_valid    (out_ch.valid),
    .i_out_ready    (out_ch.ready),
    .i_mapped_index (out_ch.mapped_index),
    .i_found        (out_ch.found),
    .i_status       (out_ch.status)
);

[bench/sit_translation_checker.sv]
`timescale 1ns / 1ps
// Checker for the subset index translator: mirrors tables and registers, predicts, compares.
module sit_translation_checker import sit_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sit_in_if    in_ch,
    sit_out_if   out_ch,
    sit_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // One translation result as it should leave the block
    typedef struct packed {
        logic [IDX_W-1:0] mapped_index;
        logic             found;
        t_status          status;
    } t_translation;

    typedef enum {SRCH_LOCAL, SRCH_REMOTE_PARENT, SRCH_REMOTE_SUBSET} t_search_tbl;

    // Shadow copy of registers and tables
    t_cfg             regs;
    logic [IDX_W-1:0] local_parent  [LOCAL_DEPTH_DEF];
    logic [IDX_W-1:0] remote_parent [REMOTE_DEPTH_DEF];
    logic [IDX_W-1:0] remote_subset [REMOTE_DEPTH_DEF];
    logic [IDX_W-1:0] local_used;
    logic [IDX_W-1:0] remote_used;
    t_translation     pending_translations [$];
    int               mismatches;

    function automatic logic [IDX_W-1:0] entry_at(input t_search_tbl tbl,
                                                  input logic [IDX_W-1:0] slot);
        case (tbl)
            SRCH_LOCAL:         return local_parent[slot];
            SRCH_REMOTE_PARENT: return remote_parent[slot];
            default:            return remote_subset[slot];
        endcase
    endfunction

    // First slot in [0, used) whose entry is not below key, or used if there is none
    function automatic logic [IDX_W-1:0] lower_bound_slot(input t_search_tbl tbl,
                                                          input logic [IDX_W-1:0] used,
                                                          input logic [IDX_W-1:0] key);
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] mid;
        lo = '0;
        hi = used;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (entry_at(tbl, mid) < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Apply one command to the shadow state and return the result it produces
    function automatic t_translation translate_index(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [IDX_W-1:0] rsub);
        t_translation     r;
        logic [IDX_W-1:0] pos;
        r.mapped_index = '0;
        r.found        = 1'b0;
        r.status       = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                local_used  = '0;
                remote_used = '0;
            end
            CMD_APPEND_LOCAL: begin
                if (local_used >= LOCAL_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    local_parent[local_used] = idx;
                    r.mapped_index = local_used;
                    r.found        = 1'b1;
                    local_used     = local_used + 1;
                end
            end
            CMD_APPEND_REMOTE: begin
                if (remote_used >= REMOTE_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    remote_parent[remote_used] = idx;
                    remote_subset[remote_used] = rsub;
                    r.mapped_index = remote_used;
                    r.found        = 1'b1;
                    remote_used    = remote_used + 1;
                end
            end
            CMD_FWD: begin
                if (idx >= regs.parent_total) begin
                    r.status = ST_RANGE;
                end else if (idx >= regs.parent_first && idx < regs.parent_limit) begin
                    pos = lower_bound_slot(SRCH_LOCAL, local_used, idx);
                    if (pos < local_used && local_parent[pos] == idx) begin
                        // slot plus subset base, wraps at 32 bits
                        r.mapped_index = pos + regs.subset_first;
                        r.found        = 1'b1;
                    end
                end else begin
                    pos = lower_bound_slot(SRCH_REMOTE_PARENT, remote_used, idx);
                    if (pos < remote_used && remote_parent[pos] == idx) begin
                        r.mapped_index = remote_subset[pos];
                        r.found        = 1'b1;
                    end
                end
            end
            CMD_REV: begin
                if (idx >= regs.subset_total) begin
                    r.status = ST_RANGE;
                end else if (idx >= regs.subset_first && idx < regs.subset_limit) begin
                    pos = idx - regs.subset_first;
                    if (pos < local_used) begin
                        r.mapped_index = local_parent[pos];
                        r.found        = 1'b1;
                    end else begin
                        r.status = ST_MISS;
                    end
                end else begin
                    pos = lower_bound_slot(SRCH_REMOTE_SUBSET, remote_used, idx);
                    if (pos < remote_used && remote_subset[pos] == idx) begin
                        r.mapped_index = remote_parent[pos];
                        r.found        = 1'b1;
                    end else begin
                        r.status = ST_MISS;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_translation want;
        if (!i_rst_n) begin
            regs        = '0;
            local_used  = '0;
            remote_used = '0;
            mismatches  = 0;
            pending_translations.delete();
        end else begin
            // results first: a result never belongs to the command accepted at the same edge
            if (out_ch.valid && out_ch.ready) begin
                if (pending_translations.size() == 0) begin
                    $display("%0t: result with nothing expected: %s=%h found=%b status=%0d",
                             $time, "mapped_index", out_ch.mapped_index, out_ch.found,
                             out_ch.status);
                    mismatches++;
                end else begin
                    want = pending_translations.pop_front();
                    if (out_ch.mapped_index !== want.mapped_index) begin
                        $display("%0t: mapped_index expected %h actual %h",
                                 $time, want.mapped_index, out_ch.mapped_index);
                        mismatches++;
                    end
                    if (out_ch.found !== want.found) begin
                        $display("%0t: found expected %b actual %b",
                                 $time, want.found, out_ch.found);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_ch.status);
                        mismatches++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_PARENT_FIRST: regs.parent_first = cfg_ch.data;
                    REG_PARENT_LIMIT: regs.parent_limit = cfg_ch.data;
                    REG_PARENT_TOTAL: regs.parent_total = cfg_ch.data;
                    REG_SUBSET_FIRST: regs.subset_first = cfg_ch.data;
                    REG_SUBSET_LIMIT: regs.subset_limit = cfg_ch.data;
                    REG_SUBSET_TOTAL: regs.subset_total = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_translations.insert(pending_translations.size(),
                                            translate_index(in_ch.command, in_ch.index_value,
                                                            in_ch.remote_subset_value));
            end
        end
        o_pending    <= pending_translations.size();
        o_fail_count <= mismatches;
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the subset index translator: clock, reset, stimulus and verdict.
module tb_top import sit_pkg::*; ;

    localparam int ITEM_BUDGET    = 1350;
    // full-table run: both tables two past capacity, 20 lookups and two end probes
    localparam int FULL_ITEMS     = LOCAL_DEPTH_DEF + REMOTE_DEPTH_DEF + 26;
    localparam int PHASE_ITEMS    = ITEM_BUDGET - FULL_ITEMS;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // well above hold-off plus a full-table search
    localparam int DRAIN_CYCLES   = 24;    // covers the slowest search after the last result
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
    localparam logic [IDX_W-1:0] ALL_ONES     = '1;

    logic i_clk;
    logic i_rst_n;

    sit_in_if  in_ch ();
    sit_out_if out_ch ();
    sit_cfg_if cfg_ch ();

    int               fail_count;
    int               pending_count;
    int               counted_items;
    int               idle_cycles;
    int               hold_left;
    logic             quiet;
    logic             hold_toggle;
    logic             hold_seen;
    logic [IDX_W-1:0] local_loaded [$];
    logic [IDX_W-1:0] remote_parent_loaded [$];
    logic [IDX_W-1:0] remote_subset_loaded [$];

    subset_index_translator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    sit_translation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result receiver: random stalls, quiet stretches, and a counted hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("subset_index_translator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one command and wait for its transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [IDX_W-1:0] rsub);
        if (!quiet && $urandom_range(99) < 15) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.command             <= cmd;
        in_ch.index_value         <= idx;
        in_ch.remote_subset_value <= rsub;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        counted_items++;
        // keep a list of loaded keys so lookups can aim at hits
        case (cmd)
            CMD_CLEAR: begin
                local_loaded.delete();
                remote_parent_loaded.delete();
                remote_subset_loaded.delete();
            end
            CMD_APPEND_LOCAL: local_loaded.insert(local_loaded.size(), idx);
            CMD_APPEND_REMOTE: begin
                remote_parent_loaded.insert(remote_parent_loaded.size(), idx);
                remote_subset_loaded.insert(remote_subset_loaded.size(), rsub);
            end
            default: ;
        endcase
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Write the whole register set; only called while nothing is in flight
    task automatic write_regs(input t_cfg c);
        cfg_put(REG_PARENT_FIRST, c.parent_first);
        cfg_put(REG_PARENT_LIMIT, c.parent_limit);
        cfg_put(REG_PARENT_TOTAL, c.parent_total);
        cfg_put(REG_SUBSET_FIRST, c.subset_first);
        cfg_put(REG_SUBSET_LIMIT, c.subset_limit);
        cfg_put(REG_SUBSET_TOTAL, c.subset_total);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected result has been received
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Short directed sequence over a small hand-picked layout
    task automatic run_directed();
        t_cfg c;
        c.parent_first = 32'd100;
        c.parent_limit = 32'd200;
        c.parent_total = 32'd1000;
        c.subset_first = 32'd10;
        c.subset_limit = 32'd20;
        c.subset_total = 32'd50;
        write_regs(c);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_FWD, 32'd150, '0);               // empty local table
        send_item(CMD_REV, 32'd12, '0);                // local offset beyond count
        send_item(CMD_REV, 32'd30, '0);                // empty remote table
        send_item(CMD_APPEND_LOCAL, 32'd120, ALL_ONES);
        send_item(CMD_APPEND_LOCAL, 32'd130, '0);
        send_item(CMD_APPEND_LOCAL, 32'd150, '0);
        send_item(CMD_APPEND_REMOTE, 32'd500, 32'd30);
        send_item(CMD_APPEND_REMOTE, 32'd700, 32'd40);
        send_item(CMD_FWD, 32'd130, '0);               // local hit
        send_item(CMD_FWD, 32'd140, '0);               // local miss
        send_item(CMD_FWD, 32'd1000, '0);              // at parent total
        send_item(CMD_FWD, ALL_ONES, '0);
        send_item(CMD_FWD, 32'd500, '0);               // remote hit
        send_item(CMD_FWD, 32'd600, '0);               // remote miss
        send_item(CMD_REV, 32'd11, '0);                // local offset hit
        send_item(CMD_REV, 32'd40, '0);                // remote hit
        send_item(CMD_REV, 32'd35, '0);                // remote miss
        send_item(CMD_REV, 32'd50, '0);                // at subset total
        send_item(CMD_REV, ALL_ONES, '0);
        send_item(CMD_UNDEF_LO, ALL_ONES, ALL_ONES);
        send_item(CMD_UNDEF_HI, '0, '0);
        send_item(CMD_APPEND_LOCAL, 32'd125, '0);      // out of order load
        send_item(CMD_FWD, 32'd125, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_FWD, 32'd130, '0);
    endtask

    // One random phase: new register set, table load, then a mix of lookups
    task automatic run_phase(input int n);
        t_cfg             c;
        int               n_loc;
        int               n_rem;
        int               n_look;
        int               sel;
        logic [63:0]      span;
        logic [63:0]      step;
        logic [63:0]      key;
        logic [63:0]      skey;
        logic [IDX_W-1:0] idx;
        wait_drained();
        quiet <= (n % 7 == 2);
        case (n % 5)
            0: begin
                c.parent_first = $urandom_range(32'h0FFF_FFFF);
                c.parent_limit = c.parent_first + $urandom_range(1, 5000);
                c.parent_total = c.parent_limit + $urandom_range(100000);
                c.subset_first = $urandom_range(32'h0FFF_FFFF);
                c.subset_limit = c.subset_first + $urandom_range(64);
                c.subset_total = c.subset_limit + $urandom_range(100000);
            end
            1: c = '0;
            2: begin
                c.parent_first = '0;
                c.parent_limit = ALL_ONES;
                c.parent_total = ALL_ONES;
                c.subset_first = '0;
                c.subset_limit = $urandom_range(40);
                c.subset_total = ALL_ONES;
            end
            3: begin
                // subset base near the top so slot plus base wraps
                c.parent_first = 32'hFFFF_0000;
                c.parent_limit = ALL_ONES;
                c.parent_total = ALL_ONES;
                c.subset_first = ALL_ONES - $urandom_range(15);
                c.subset_limit = ALL_ONES;
                c.subset_total = ALL_ONES;
            end
            default: c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
        write_regs(c);
        if (n % 4 != 3) send_item(CMD_CLEAR, $urandom, $urandom);

        // local keys ascending inside the owned parent window, with an occasional random key
        n_loc = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        span  = (c.parent_limit > c.parent_first) ? c.parent_limit - c.parent_first : 0;
        step  = span / (n_loc + 1);
        if (step == 0) step = 1;
        if (step > 1000) step = 1000;
        key = c.parent_first + $urandom_range(step - 1);
        for (int i = 0; i < n_loc; i++) begin
            idx = ($urandom_range(19) == 0) ? $urandom : key[IDX_W-1:0];
            send_item(CMD_APPEND_LOCAL, idx, $urandom);
            key += $urandom_range(1, step);
        end

        // remote pairs above both local windows, both columns ascending
        n_rem = $urandom_range(12);
        key   = c.parent_limit + $urandom_range(20);
        skey  = c.subset_limit + $urandom_range(3);
        for (int i = 0; i < n_rem; i++) begin
            send_item(CMD_APPEND_REMOTE, key[IDX_W-1:0], skey[IDX_W-1:0]);
            key  += $urandom_range(1, 50);
            skey += $urandom_range(1, 5);
        end

        if (n == 5) hold_toggle <= ~hold_toggle;

        n_look = $urandom_range(20, 60);
        for (int i = 0; i < n_look; i++) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                idx = (local_loaded.size() > 0) ?
                      local_loaded[$urandom_range(local_loaded.size() - 1)] : $urandom;
                send_item(CMD_FWD, idx, $urandom);
            end else if (sel < 40) begin
                idx = (remote_parent_loaded.size() > 0) ?
                      remote_parent_loaded[$urandom_range(remote_parent_loaded.size() - 1)] :
                      $urandom;
                send_item(CMD_FWD, idx, $urandom);
            end else if (sel < 48) begin
                send_item(CMD_FWD, c.parent_first + $urandom_range(5000), $urandom);
            end else if (sel < 55) begin
                send_item(CMD_FWD, $urandom, $urandom);
            end else if (sel < 58) begin
                send_item(CMD_FWD, c.parent_total - $urandom_range(1), $urandom);
            end else if (sel < 70) begin
                send_item(CMD_REV, c.subset_first + $urandom_range(n_loc + 3), $urandom);
            end else if (sel < 80) begin
                idx = (remote_subset_loaded.size() > 0) ?
                      remote_subset_loaded[$urandom_range(remote_subset_loaded.size() - 1)] :
                      $urandom;
                send_item(CMD_REV, idx, $urandom);
            end else if (sel < 86) begin
                send_item(CMD_REV, $urandom, $urandom);
            end else if (sel < 88) begin
                send_item(CMD_REV, c.subset_total - $urandom_range(1), $urandom);
            end else if (sel < 90) begin
                send_item(CMD_APPEND_LOCAL, $urandom, $urandom);
            end else if (sel < 92) begin
                send_item(CMD_APPEND_REMOTE, $urandom, $urandom);
            end else if (sel < 95) begin
                send_item($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO), $urandom, $urandom);
            end else if (sel < 97) begin
                wait_drained();
            end else if (sel < 98) begin
                send_item(CMD_CLEAR, $urandom, $urandom);
            end else if (sel < 99) begin
                send_item(CMD_FWD, ALL_ONES, ALL_ONES);
            end else begin
                send_item(CMD_REV, ALL_ONES, ALL_ONES);
            end
        end
    endtask

    // Fill both tables past capacity under a receiver hold-off, then search them
    task automatic run_full_tables();
        t_cfg        c;
        int          sel;
        logic [63:0] key;
        wait_drained();
        quiet <= 1'b0;
        c.parent_first = '0;
        c.parent_limit = 32'h8000_0000;
        c.parent_total = ALL_ONES;
        c.subset_first = 32'hFFFF_FE00;
        c.subset_limit = ALL_ONES;
        c.subset_total = ALL_ONES;
        write_regs(c);
        send_item(CMD_CLEAR, '0, '0);
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < LOCAL_DEPTH_DEF + 2; i++) begin
            key = i * 5 + $urandom_range(3);
            send_item(CMD_APPEND_LOCAL, key[IDX_W-1:0], $urandom);
        end
        // remote load and searches run without idling on either side
        quiet <= 1'b1;
        for (int i = 0; i < REMOTE_DEPTH_DEF + 2; i++) begin
            key = 64'h8000_0000 + i * 1000 + $urandom_range(99);
            send_item(CMD_APPEND_REMOTE, key[IDX_W-1:0], i * 7 + $urandom_range(5));
        end
        for (int i = 0; i < 20; i++) begin
            sel = $urandom_range(3);
            case (sel)
                0: send_item(CMD_FWD, local_loaded[$urandom_range(LOCAL_DEPTH_DEF - 1)], '0);
                1: send_item(CMD_FWD,
                             remote_parent_loaded[$urandom_range(REMOTE_DEPTH_DEF - 1)], '0);
                2: send_item(CMD_REV, c.subset_first + $urandom_range(32'h1FF), '0);
                default: send_item(CMD_REV,
                             remote_subset_loaded[$urandom_range(REMOTE_DEPTH_DEF - 1)], '0);
            endcase
        end
        send_item(CMD_FWD, local_loaded[0], '0);
        send_item(CMD_FWD, local_loaded[LOCAL_DEPTH_DEF - 1], '0);
    endtask

    // Main sequence
    initial begin
        int phase_no;
        i_rst_n                   <= 1'b0;
        in_ch.valid               <= 1'b0;
        in_ch.command             <= CMD_CLEAR;
        in_ch.index_value         <= '0;
        in_ch.remote_subset_value <= '0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.index              <= REG_PARENT_FIRST;
        cfg_ch.data               <= '0;
        quiet                     <= 1'b0;
        hold_toggle               <= 1'b0;
        counted_items = 0;
        phase_no      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        while (counted_items < PHASE_ITEMS) begin
            run_phase(phase_no);
            phase_no++;
        end
        run_full_tables();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("subset_index_translator verification clean");
        end else begin
            $display("subset_index_translator verification failed");
        end
        $finish;
    end

endmodule
